[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is low.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked implication with the consequent checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/euq_pkg.sv]
`timescale 1ns / 1ps
package euq_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;
    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [32:0] PI_Q30 = 33'sd3373259426;
    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [32:0] z;
        logic flip;
    } t_lane;

    function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0: v = 33'sh03243F6A8;
            5'd1: v = 33'sh01DAC6705;
            5'd2: v = 33'sh00FADBAFC;
            5'd3: v = 33'sh007F56EA6;
            5'd4: v = 33'sh003FEAB76;
            5'd5: v = 33'sh001FFD55B;
            5'd6: v = 33'sh000FFFAAA;
            5'd7: v = 33'sh0007FFF55;
            5'd8: v = 33'sh0003FFFEA;
            5'd9: v = 33'sh0001FFFFD;
            5'd10: v = 33'sh0000FFFFF;
            5'd11: v = 33'sh00007FFFF;
            5'd12: v = 33'sh00003FFFF;
            5'd13: v = 33'sh00001FFFF;
            5'd14: v = 33'sh00000FFFF;
            5'd15: v = 33'sh000007FFF;
            5'd16: v = 33'sh000003FFF;
            5'd17: v = 33'sh000001FFF;
            5'd18: v = 33'sh000000FFF;
            5'd19: v = 33'sh0000007FF;
            5'd20: v = 33'sh0000003FF;
            5'd21: v = 33'sh0000001FF;
            5'd22: v = 33'sh0000000FF;
            5'd23: v = 33'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/euq_cordic_cell.sv]
`timescale 1ns / 1ps
module euq_cordic_cell (
    input  logic           i_clk,
    input  logic           i_ce,
    input  logic [4:0]     i_step,
    input  euq_pkg::t_lane i_lane,
    output euq_pkg::t_lane o_lane
);
    import euq_pkg::*;

    t_lane r_lane;
    t_lane n_lane;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] at;

    always_comb begin
        dx = i_lane.y >>> i_step;
        dy = i_lane.x >>> i_step;
        at = atan_q30(i_step);
        n_lane = i_lane;
        if (!i_lane.z[32]) begin
            n_lane.x = i_lane.x - dx;
            n_lane.y = i_lane.y + dy;
            n_lane.z = i_lane.z - at;
        end else begin
            n_lane.x = i_lane.x + dx;
            n_lane.y = i_lane.y - dy;
            n_lane.z = i_lane.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

[hdl/euq_quat.sv]
`timescale 1ns / 1ps
module euq_quat (
    input  logic               i_clk,
    input  logic               i_ce,
    input  euq_pkg::t_lane     i_lx,
    input  euq_pkg::t_lane     i_ly,
    input  euq_pkg::t_lane     i_lz,
    output logic signed [15:0] o_qx,
    output logic signed [15:0] o_qy,
    output logic signed [15:0] o_qz,
    output logic signed [15:0] o_qw
);
    import euq_pkg::*;

    logic signed [31:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    logic signed [31:0] r_sxcy, r_cxsy, r_cxcy, r_sxsy;
    logic signed [31:0] r_sz1, r_cz1;
    logic signed [31:0] r_t [8];
    logic signed [15:0] r_q [4];
    logic signed [32:0] sum [4];

    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [33:0] r;
        logic signed [17:0] s;
        r = 34'(v) + 34'sd32768;
        s = r[33:16];
        if (s > ONE_Q14) s = ONE_Q14;
        if (s < -ONE_Q14) s = -ONE_Q14;
        return s[15:0];
    endfunction

    always_comb begin
        sum[0] = 33'(r_t[0]) - 33'(r_t[1]);
        sum[1] = 33'(r_t[2]) + 33'(r_t[3]);
        sum[2] = 33'(r_t[4]) - 33'(r_t[5]);
        sum[3] = 33'(r_t[6]) + 33'(r_t[7]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // undo range reduction
            r_sx <= i_lx.flip ? -i_lx.y : i_lx.y;
            r_cx <= i_lx.flip ? -i_lx.x : i_lx.x;
            r_sy <= i_ly.flip ? -i_ly.y : i_ly.y;
            r_cy <= i_ly.flip ? -i_ly.x : i_ly.x;
            r_sz <= i_lz.flip ? -i_lz.y : i_lz.y;
            r_cz <= i_lz.flip ? -i_lz.x : i_lz.x;
            r_sxcy <= mulq(r_sx, r_cy);
            r_cxsy <= mulq(r_cx, r_sy);
            r_cxcy <= mulq(r_cx, r_cy);
            r_sxsy <= mulq(r_sx, r_sy);
            r_sz1 <= r_sz;
            r_cz1 <= r_cz;
            r_t[0] <= mulq(r_sxcy, r_cz1);
            r_t[1] <= mulq(r_cxsy, r_sz1);
            r_t[2] <= mulq(r_cxsy, r_cz1);
            r_t[3] <= mulq(r_sxcy, r_sz1);
            r_t[4] <= mulq(r_cxcy, r_sz1);
            r_t[5] <= mulq(r_sxsy, r_cz1);
            r_t[6] <= mulq(r_cxcy, r_cz1);
            r_t[7] <= mulq(r_sxsy, r_sz1);
            for (int k = 0; k < 4; k++) begin
                r_q[k] <= to_q14(sum[k]);
            end
        end
    end

    assign o_qx = r_q[0];
    assign o_qy = r_q[1];
    assign o_qz = r_q[2];
    assign o_qw = r_q[3];
endmodule

[hdl/euler_to_quaternion.sv]
`timescale 1ns / 1ps
// Euler angles (x-y-z, Q2.13 radians) to a unit quaternion (Q1.14, clamped to +-1).
// Fully pipelined: one angle triple is taken per cycle while the skid is empty. Each
// result passes through one range-reduction stage, one CORDIC cell per iteration
// for each angle, then sign fix, two multiply stages and a round/clamp stage.
// An output register with a one-beat skid keeps input beats flowing while a result
// waits; the whole pipe holds only when the skid is occupied.
module euler_to_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // angle_x, angle_y, angle_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // quat_x, quat_y, quat_z, quat_w
);
    import euq_pkg::*;

    localparam int LAT = NSTEPS + 5;

    logic              ce;
    logic [LAT-1:0]    r_vld;
    t_lane             r_prep [3];
    t_lane             w_lane [3][NSTEPS+1];
    logic signed [15:0] qx, qy, qz, qw;
    logic [63:0]       pipe_data;
    logic [63:0]       r_out_data, r_skid_data;
    logic              r_out_valid, r_skid_valid;
    logic              out_take;
    logic signed [32:0] z0 [3];

    assign ce = !r_skid_valid;
    assign s_axis_tready = ce;
    assign out_take = r_out_valid && m_axis_tready;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            z0[a] = {s_axis_tdata[16*a+15], s_axis_tdata[16*a +: 16], 16'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 3; a++) begin
                r_prep[a].x <= GAIN_INV_Q30;
                r_prep[a].y <= '0;
                if (z0[a] > HALF_PI_Q30) begin
                    r_prep[a].z <= z0[a] - PI_Q30;
                    r_prep[a].flip <= 1'b1;
                end else if (z0[a] < -HALF_PI_Q30) begin
                    r_prep[a].z <= z0[a] + PI_Q30;
                    r_prep[a].flip <= 1'b1;
                end else begin
                    r_prep[a].z <= z0[a];
                    r_prep[a].flip <= 1'b0;
                end
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_lane[a][0] = r_prep[a];
        for (genvar k = 0; k < NSTEPS; k++) begin : g_step
            euq_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_ce   (ce),
                .i_step (5'(k)),
                .i_lane (w_lane[a][k]),
                .o_lane (w_lane[a][k+1])
            );
        end
    end

    euq_quat u_quat (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_lx  (w_lane[0][NSTEPS]),
        .i_ly  (w_lane[1][NSTEPS]),
        .i_lz  (w_lane[2][NSTEPS]),
        .o_qx  (qx),
        .o_qy  (qy),
        .o_qz  (qz),
        .o_qw  (qw)
    );

    assign pipe_data = {qw, qz, qy, qx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid first; pipe holds meanwhile
            if (out_take) begin
                r_out_data <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
            if (r_vld[LAT-1]) begin
                if (!r_out_valid || out_take) begin
                    r_out_data <= pipe_data;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_data <= pipe_data;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;

`include "assert_macros.svh"

    `CHK_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `CHK_NEXT(a_skid_fill, i_clk, i_rst_n, r_out_valid && !m_axis_tready && r_vld[LAT-1] && !r_skid_valid, r_skid_valid, "result lost on stall")
    `CHK_IMPL(a_qx_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[15:0]) >= -16'sd16384), "quat_x out of range")
    `CHK_IMPL(a_qw_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[63:48]) <= 16'sd16384) && ($signed(m_axis_tdata[63:48]) >= -16'sd16384), "quat_w out of range")

endmodule

[tb/euler_to_quaternion_tb.sv]
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
    import euq_pkg::*;

    typedef struct packed {
        logic signed [15:0] ang_z;
        logic signed [15:0] ang_y;
        logic signed [15:0] ang_x;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
    } t_quat;

    localparam int NUM_RANDOM = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // angle_x, angle_y, angle_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;      // quat_x, quat_y, quat_z, quat_w

    t_angles angle_queue[$];
    t_quat   quat_expected[$];
    int      error_count = 0;
    bit      stim_loaded = 1'b0;
    bit      quiet_tail = 1'b0;
    bit      src_taken = 1'b0;
    int      hold_off = 0;
    int      long_hold = 0;
    int      src_gap = 0;
    int      sink_gap = 0;

    euler_to_quaternion dut (.*);

    always #2 i_clk = ~i_clk;

    // 33-bit atan entry, sign-extended to a 64-bit signed value
    function automatic longint atan_entry(input int idx);
        logic signed [32:0] v;
        v = atan_q30(idx[4:0]);
        return longint'(v);
    endfunction

    function automatic void half_sin_cos(input logic signed [15:0] ang,
                                         output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 1686629713) begin
            z -= longint'(PI_Q30);
            flip = 1'b1;
        end else if (z < -1686629713) begin
            z += longint'(PI_Q30);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint triple_product(input longint a, input longint b,
                                              input longint c);
        return (((a * b) >>> 30) * c) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_clamp_q14(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic t_quat euler_to_quat(input t_angles a);
        longint sx, cx, sy, cy, sz, cz;
        t_quat q;
        half_sin_cos(a.ang_x, sx, cx);
        half_sin_cos(a.ang_y, sy, cy);
        half_sin_cos(a.ang_z, sz, cz);
        q.qx = round_clamp_q14(triple_product(sx, cy, cz) - triple_product(cx, sy, sz));
        q.qy = round_clamp_q14(triple_product(cx, sy, cz) + triple_product(sx, cy, sz));
        q.qz = round_clamp_q14(triple_product(cx, cy, sz) - triple_product(sx, sy, cz));
        q.qw = round_clamp_q14(triple_product(cx, cy, cz) + triple_product(sx, sy, sz));
        return q;
    endfunction

    function automatic logic signed [15:0] pick_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'(32767 - $urandom_range(0, 3));
        if (r == 1) return 16'(-32768 + $urandom_range(0, 3));
        // near the +-pi/2 half-angle fold: |ang| around 25736
        if (r == 2) return 16'(25736 + $urandom_range(0, 8) - 4);
        if (r == 3) return 16'(-25736 + $urandom_range(0, 8) - 4);
        if (r == 4) return 16'($urandom_range(0, 64) - 32);
        return 16'($urandom);
    endfunction

    initial begin
        logic signed [15:0] edge_vals[10];
        t_angles a;
        edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
                      16'sd25736, -16'sd25736, 16'sd25737, -16'sd25737, 16'sd12868};
        for (int i = 0; i < 10; i++) begin
            a.ang_x = edge_vals[i];
            a.ang_y = edge_vals[(i + 3) % 10];
            a.ang_z = edge_vals[(i + 7) % 10];
            angle_queue.push_back(a);
        end
        angle_queue.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        angle_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        angle_queue.push_back('{16'sh5555, 16'shAAAA, 16'sh5555});
        angle_queue.push_back('{16'shAAAA, 16'sh5555, 16'shAAAA});
        for (int i = 0; i < NUM_RANDOM; i++) begin
            a.ang_x = pick_angle();
            a.ang_y = pick_angle();
            a.ang_z = pick_angle();
            angle_queue.push_back(a);
        end
        stim_loaded = 1'b1;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver; advance only when no beat is pending or the last rising edge took it
    always @(negedge i_clk) begin
        if (i_rst_n && stim_loaded) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!s_axis_tvalid || src_taken) begin
                if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                    src_gap <= $urandom_range(1, 9);
                    s_axis_tvalid <= 1'b0;
                end else if (angle_queue.size() > 0) begin
                    s_axis_tdata <= angle_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            quiet_tail <= angle_queue.size() < 150;
        end
    end

    // predict at acceptance
    always @(posedge i_clk) begin
        src_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            quat_expected.push_back(euler_to_quat(t_angles'(s_axis_tdata)));
    end

    // receiver stalls, with one long hold-off once the pipe is well loaded
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (long_hold == 0 && angle_queue.size() < 1200 && angle_queue.size() > 0) begin
                long_hold <= 1;
                hold_off <= 80;
                m_axis_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 12) == 0) begin
                sink_gap <= $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_quat'(m_axis_tdata);
            if (quat_expected.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = quat_expected.pop_front();
                if (got.qx !== want.qx) begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, want.qx, got.qx);
                    error_count++;
                end
                if (got.qy !== want.qy) begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, want.qy, got.qy);
                    error_count++;
                end
                if (got.qz !== want.qz) begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, want.qz, got.qz);
                    error_count++;
                end
                if (got.qw !== want.qw) begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, want.qw, got.qw);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stim_loaded && i_rst_n);
        wait (angle_queue.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        while (quat_expected.size() > 0) @(posedge i_clk);
        repeat (CORDIC_STEPS + 40) @(posedge i_clk);
        if (error_count == 0 && quat_expected.size() == 0)
            $display("euler_to_quaternion test passed");
        else
            $display("euler_to_quaternion test failed");
        $finish;
    end

    initial begin
        #400000;
        $display("euler_to_quaternion test failed");
        $finish;
    end

endmodule

[euler_to_quaternion.f]
+incdir+hdl
hdl/euq_pkg.sv
hdl/euq_cordic_cell.sv
hdl/euq_quat.sv
hdl/euler_to_quaternion.sv
tb/euler_to_quaternion_tb.sv
